// File: rtl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and constants for the cursor list store: command codes, cell
// operation codes and default sizes.
// ----------------------------------------------------------------------------
package cls_pkg;

  // Default sizes of the store
  localparam int DEF_CAPACITY     = 64;
  localparam int DEF_ELEMENT_BITS = 32;

  // Fixed widths of the reported fields
  localparam int CMD_W   = 4;
  localparam int COUNT_W = 7;
  localparam int WORD_W  = 32;

  // Cells gathered per first-level group when reading back and cursor values
  localparam int GRP_SIZE = 8;

  // Command codes carried by an input beat
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 4'd0,
    CMD_PREPEND    = 4'd1,
    CMD_APPEND     = 4'd2,
    CMD_INS_BEFORE = 4'd3,
    CMD_INS_AFTER  = 4'd4,
    CMD_DEL_FRONT  = 4'd5,
    CMD_DEL_BACK   = 4'd6,
    CMD_DEL_CURSOR = 4'd7,
    CMD_MV_FRONT   = 4'd8,
    CMD_MV_BACK    = 4'd9,
    CMD_MV_PREV    = 4'd10,
    CMD_MV_NEXT    = 4'd11,
    CMD_SET        = 4'd12,
    CMD_READ       = 4'd13
  } cls_cmd_t;

  // Operation broadcast along the row of cells
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_WRITE  = 2'd3
  } cls_op_t;

endpackage

// File: rtl/cursor_list_store_core.sv
// ----------------------------------------------------------------------------
// cursor_list_store_core
// Bounded ordered list of signed words with one cursor, held in a row of
// shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries cmd and value; one beat is one
//   command. Output channel (out_valid / out_stall) returns one status beat
//   per command: count, cursor_pos, cursor_ok, front, back and cursor values
//   and error, all describing the list after the command.
//   The list update itself happens at the edge that takes the input beat:
//   every cell shifts, loads or holds in parallel. The back and cursor values
//   are then collected over the row by a two-level gather: the first level is
//   registered, the second feeds the output register. A new command is taken
//   only once the previous result has been loaded into the output register.
//   The output register holds a finished result while out_stall is high; the
//   next command is still taken, and its result waits in the gather stage
//   until the output register is free, during which in_stall stays high.
//   A refused command (precondition failed or store full) returns error = 1
//   and leaves the list untouched.
//   Reset (rst, synchronous) empties the list, drops the cursor and clears
//   both channels. Cell contents are not cleared; only cells below the
//   count are ever read.
// ----------------------------------------------------------------------------
module cursor_list_store_core #(
  parameter int CAPACITY     = cls_pkg::DEF_CAPACITY,
  parameter int ELEMENT_BITS = cls_pkg::DEF_ELEMENT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cls_pkg::CMD_W-1:0]            cmd,
  input  logic signed [cls_pkg::WORD_W-1:0]    value,
  // status channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cls_pkg::COUNT_W-1:0]          count,
  output logic signed [cls_pkg::COUNT_W-1:0]   cursor_pos,
  output logic                                 cursor_ok,
  output logic signed [cls_pkg::WORD_W-1:0]    front_value,
  output logic signed [cls_pkg::WORD_W-1:0]    back_value,
  output logic signed [cls_pkg::WORD_W-1:0]    cursor_value,
  output logic                                 error
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int GRP    = cls_pkg::GRP_SIZE;
  localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
  localparam int EB     = ELEMENT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_MERGE  = 3'b100
  } state_t;

  state_t state, state_next;

  // list bookkeeping
  logic [FILL_W-1:0] fill, fill_next;
  logic [IDX_W-1:0]  cursor_at, cursor_next;
  logic              cursor_def, def_next;
  logic              err_q, err_next;

  // broadcast to the cells
  cls_pkg::cls_op_t op_dec, cell_op;
  logic [IDX_W-1:0] pos_dec;
  logic [EB-1:0]    elem;
  logic [EB-1:0]    cell_q [CAPACITY];

  // gather stage
  logic [EB-1:0] grp_back [NGRP];
  logic [EB-1:0] grp_cur  [NGRP];
  logic [EB-1:0] grp_back_next [NGRP];
  logic [EB-1:0] grp_cur_next  [NGRP];
  logic [EB-1:0] back_all, cur_all;

  logic              take, load_out, full;
  logic [FILL_W-1:0] fill_inc, fill_dec;
  logic [IDX_W-1:0]  back_idx, cur_inc, cur_dec;
  logic [IDX_W:0]    cur_inc_w;

  assign take     = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign load_out = (state == ST_MERGE) && (!out_valid || !out_stall);

  assign elem      = EB'(value);
  assign full      = (fill == FILL_W'(CAPACITY));
  assign fill_inc  = fill + 1'b1;
  assign fill_dec  = fill - 1'b1;
  assign back_idx  = fill_dec[IDX_W-1:0];
  assign cur_inc_w = {1'b0, cursor_at} + 1'b1;
  assign cur_inc   = cur_inc_w[IDX_W-1:0];
  assign cur_dec   = cursor_at - 1'b1;

  // Decode the command into a cell operation and the new bookkeeping
  always_comb begin
    op_dec      = cls_pkg::OP_HOLD;
    pos_dec     = '0;
    err_next    = 1'b0;
    fill_next   = fill;
    cursor_next = cursor_at;
    def_next    = cursor_def;
    case (cls_pkg::cls_cmd_t'(cmd))
      cls_pkg::CMD_CLEAR: begin
        fill_next   = '0;
        cursor_next = '0;
        def_next    = 1'b0;
      end
      cls_pkg::CMD_PREPEND: begin
        if (full) begin
          err_next = 1'b1;
        end else begin
          op_dec    = cls_pkg::OP_INSERT;
          fill_next = fill_inc;
          if (cursor_def) begin
            cursor_next = cur_inc;
          end
        end
      end
      cls_pkg::CMD_APPEND: begin
        if (full) begin
          err_next = 1'b1;
        end else begin
          op_dec    = cls_pkg::OP_INSERT;
          pos_dec   = fill[IDX_W-1:0];
          fill_next = fill_inc;
        end
      end
      cls_pkg::CMD_INS_BEFORE: begin
        if (full || !cursor_def) begin
          err_next = 1'b1;
        end else begin
          op_dec      = cls_pkg::OP_INSERT;
          pos_dec     = cursor_at;
          fill_next   = fill_inc;
          cursor_next = cur_inc;
        end
      end
      cls_pkg::CMD_INS_AFTER: begin
        if (full || !cursor_def) begin
          err_next = 1'b1;
        end else begin
          op_dec    = cls_pkg::OP_INSERT;
          pos_dec   = cur_inc;
          fill_next = fill_inc;
        end
      end
      cls_pkg::CMD_DEL_FRONT: begin
        if (fill == '0) begin
          err_next = 1'b1;
        end else begin
          op_dec    = cls_pkg::OP_REMOVE;
          fill_next = fill_dec;
          if (cursor_def) begin
            if (cursor_at == '0) begin
              def_next = 1'b0;
            end else begin
              cursor_next = cur_dec;
            end
          end
        end
      end
      cls_pkg::CMD_DEL_BACK: begin
        if (fill == '0) begin
          err_next = 1'b1;
        end else begin
          op_dec    = cls_pkg::OP_REMOVE;
          pos_dec   = back_idx;
          fill_next = fill_dec;
          if (cursor_def && cursor_at == back_idx) begin
            def_next    = 1'b0;
            cursor_next = '0;
          end
        end
      end
      cls_pkg::CMD_DEL_CURSOR: begin
        if (!cursor_def) begin
          err_next = 1'b1;
        end else begin
          op_dec      = cls_pkg::OP_REMOVE;
          pos_dec     = cursor_at;
          fill_next   = fill_dec;
          def_next    = 1'b0;
          cursor_next = '0;
        end
      end
      cls_pkg::CMD_MV_FRONT: begin
        if (fill != '0) begin
          def_next    = 1'b1;
          cursor_next = '0;
        end
      end
      cls_pkg::CMD_MV_BACK: begin
        if (fill != '0) begin
          def_next    = 1'b1;
          cursor_next = back_idx;
        end
      end
      cls_pkg::CMD_MV_PREV: begin
        if (cursor_def) begin
          if (cursor_at == '0) begin
            def_next = 1'b0;
          end else begin
            cursor_next = cur_dec;
          end
        end
      end
      cls_pkg::CMD_MV_NEXT: begin
        if (cursor_def) begin
          if (cur_inc_w >= fill) begin
            def_next    = 1'b0;
            cursor_next = '0;
          end else begin
            cursor_next = cur_inc;
          end
        end
      end
      cls_pkg::CMD_SET: begin
        if (!cursor_def) begin
          err_next = 1'b1;
        end else begin
          op_dec  = cls_pkg::OP_WRITE;
          pos_dec = cursor_at;
        end
      end
      default: begin
        op_dec = cls_pkg::OP_HOLD;
      end
    endcase
  end

  assign cell_op = take ? op_dec : cls_pkg::OP_HOLD;

  // Row of cells; each takes its neighbours' words for shifts
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EB-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = elem;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    cls_cell #(
      .INDEX        (i),
      .IDX_W        (IDX_W),
      .ELEMENT_BITS (EB)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .pos   (pos_dec),
      .elem  (elem),
      .left  (left_w),
      .right (right_w),
      .q     (cell_q[i])
    );
  end

  // Advance the command sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold list bookkeeping, update on each taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      cursor_at  <= '0;
      cursor_def <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        fill       <= fill_next;
        cursor_at  <= cursor_next;
        cursor_def <= def_next;
        err_q      <= err_next;
      end
    end
  end

  // First gather level: pick back and cursor words within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_back_next[g] = '0;
      grp_cur_next[g]  = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          if (fill != '0 && IDX_W'(g * GRP + k) == back_idx) begin
            grp_back_next[g] = grp_back_next[g] | cell_q[g * GRP + k];
          end
          if (cursor_def && IDX_W'(g * GRP + k) == cursor_at) begin
            grp_cur_next[g] = grp_cur_next[g] | cell_q[g * GRP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_GATHER) begin
      grp_back <= grp_back_next;
      grp_cur  <= grp_cur_next;
    end
  end

  // Second gather level: merge the groups
  always_comb begin
    back_all = '0;
    cur_all  = '0;
    for (int g = 0; g < NGRP; g++) begin
      back_all = back_all | grp_back[g];
      cur_all  = cur_all | grp_cur[g];
    end
  end

  // Drive the output register; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      count        <= cls_pkg::COUNT_W'(fill);
      cursor_pos   <= cursor_def ? cls_pkg::COUNT_W'(cursor_at) : '1;
      cursor_ok    <= cursor_def;
      front_value  <= (fill != '0) ? cls_pkg::WORD_W'($signed(cell_q[0])) : '0;
      back_value   <= cls_pkg::WORD_W'($signed(back_all));
      cursor_value <= cls_pkg::WORD_W'($signed(cur_all));
      error        <= err_q;
    end
  end

  // Checks on bookkeeping and sequencing
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(CAPACITY))
    else $error("fill exceeds capacity");

  a_cursor_in_list : assert property (@(posedge clk) disable iff (rst)
    cursor_def |-> ({1'b0, cursor_at} < {1'b0, fill}))
    else $error("defined cursor lies beyond the list");

  a_cursor_parked : assert property (@(posedge clk) disable iff (rst)
    !cursor_def |-> (cursor_at == '0))
    else $error("undefined cursor not parked at zero");

  a_refused_keeps : assert property (@(posedge clk) disable iff (rst)
    (take && err_next) |=> (fill == $past(fill) && cursor_def == $past(cursor_def)
                            && cursor_at == $past(cursor_at)))
    else $error("refused command changed the list");

  a_take_gathers : assert property (@(posedge clk) disable iff (rst)
    take |=> (state == ST_GATHER))
    else $error("taken command did not enter gather");

endmodule

// File: rtl/cls_cell.sv
// ----------------------------------------------------------------------------
// cls_cell
// One storage cell of the list row. It holds one element and, on each
// broadcast operation, keeps its word, loads the new element or takes the
// word of its left or right neighbour.
// ----------------------------------------------------------------------------
module cls_cell #(
  parameter int INDEX        = 0,
  parameter int IDX_W        = 6,
  parameter int ELEMENT_BITS = cls_pkg::DEF_ELEMENT_BITS
) (
  input  logic                    clk,
  input  cls_pkg::cls_op_t        op,
  input  logic [IDX_W-1:0]        pos,
  input  logic [ELEMENT_BITS-1:0] elem,
  input  logic [ELEMENT_BITS-1:0] left,
  input  logic [ELEMENT_BITS-1:0] right,
  output logic [ELEMENT_BITS-1:0] q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  // Shift, load or hold according to where this cell sits relative to pos
  always_ff @(posedge clk) begin
    case (op)
      cls_pkg::OP_INSERT: begin
        if (MY_IDX == pos) begin
          q <= elem;
        end else if (MY_IDX > pos) begin
          q <= left;
        end
      end
      cls_pkg::OP_REMOVE: begin
        if (MY_IDX >= pos) begin
          q <= right;
        end
      end
      cls_pkg::OP_WRITE: begin
        if (MY_IDX == pos) begin
          q <= elem;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

// File: tb/cursor_list_store_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_list_store_core_tb
// Self-checking bench for the cursor list store. A short table of directed
// commands covers empty-list refusals, extreme values, cursor moves off both
// ends and the spare command codes. Random grow and shrink runs then fill the
// store to capacity and drain it again. Each status beat is compared against
// the table's typed status or a behavioural copy of the list in the bench.
// ----------------------------------------------------------------------------
module cursor_list_store_core_tb;

  localparam int CAPACITY       = cls_pkg::DEF_CAPACITY;
  localparam int CMD_W          = cls_pkg::CMD_W;
  localparam int COUNT_W        = cls_pkg::COUNT_W;
  localparam int WORD_W         = cls_pkg::WORD_W;
  localparam int RAND_PER_PHASE = 630;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 10;

  // Spare command codes, decoded as a plain read
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 4'd14;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 4'd15;

  localparam logic signed [WORD_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] MIN_WORD = 32'sh8000_0000;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [COUNT_W-1:0] pos;
    logic                      ok;
    logic signed [WORD_W-1:0]  front;
    logic signed [WORD_W-1:0]  back;
    logic signed [WORD_W-1:0]  cur;
    logic                      err;
  } list_status_t;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
    bit                       typed;
    list_status_t             status;
  } dir_row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            cmd = cls_pkg::CMD_READ;
  logic signed [WORD_W-1:0]    value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [COUNT_W-1:0]          count;
  logic signed [COUNT_W-1:0]   cursor_pos;
  logic                        cursor_ok;
  logic signed [WORD_W-1:0]    front_value;
  logic signed [WORD_W-1:0]    back_value;
  logic signed [WORD_W-1:0]    cursor_value;
  logic                        error;

  // Bench copy of the list
  logic signed [WORD_W-1:0] list_cells [CAPACITY];
  int                       list_len = 0;
  int                       cur_idx = 0;
  bit                       cur_valid = 1'b0;

  list_status_t pending_status [$];
  dir_row_t     dir_tab [$];
  int send_idle = 0;
  int recv_idle = 0;
  int mismatch_cnt = 0;
  int beats_checked = 0;
  int cmds_sent = 0;
  int full_refusals = 0;
  int cycle_cnt = 0;

  cursor_list_store_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .count        (count),
    .cursor_pos   (cursor_pos),
    .cursor_ok    (cursor_ok),
    .front_value  (front_value),
    .back_value   (back_value),
    .cursor_value (cursor_value),
    .error        (error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the status channel at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  function automatic list_status_t mk_status(int cnt, int pos, bit ok,
                                             logic [WORD_W-1:0] f, logic [WORD_W-1:0] b,
                                             logic [WORD_W-1:0] cv, bit e);
    list_status_t s;
    s.count = cnt[COUNT_W-1:0];
    s.pos   = pos[COUNT_W-1:0];
    s.ok    = ok;
    s.front = f;
    s.back  = b;
    s.cur   = cv;
    s.err   = e;
    return s;
  endfunction

  function automatic string status_str(list_status_t s);
    return $sformatf("count=%0d pos=%0d ok=%0b front=%h back=%h cur=%h err=%0b",
                     s.count, s.pos, s.ok, s.front, s.back, s.cur, s.err);
  endfunction

  // Open a gap at pos and store v there
  function automatic void list_insert(int pos, logic signed [WORD_W-1:0] v);
    for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
    list_cells[pos] = v;
    list_len++;
  endfunction

  // Remove the element at pos and close the gap
  function automatic void list_remove(int pos);
    for (int i = pos; i < list_len - 1; i++) list_cells[i] = list_cells[i+1];
    list_len--;
  endfunction

  // Apply one command to the bench list and return the status it reports
  function automatic list_status_t apply_to_list(logic [CMD_W-1:0] c,
                                                 logic signed [WORD_W-1:0] v);
    list_status_t s;
    bit full;
    bit err;
    full = (list_len >= CAPACITY);
    err  = 1'b0;
    case (c)
      cls_pkg::CMD_CLEAR: begin
        list_len  = 0;
        cur_idx   = 0;
        cur_valid = 1'b0;
      end
      cls_pkg::CMD_PREPEND: begin
        if (full) err = 1'b1;
        else begin
          list_insert(0, v);
          if (cur_valid) cur_idx++;
        end
      end
      cls_pkg::CMD_APPEND: begin
        if (full) err = 1'b1;
        else list_insert(list_len, v);
      end
      cls_pkg::CMD_INS_BEFORE: begin
        if (full || !cur_valid) err = 1'b1;
        else begin
          list_insert(cur_idx, v);
          cur_idx++;
        end
      end
      cls_pkg::CMD_INS_AFTER: begin
        if (full || !cur_valid) err = 1'b1;
        else list_insert(cur_idx + 1, v);
      end
      cls_pkg::CMD_DEL_FRONT: begin
        if (list_len == 0) err = 1'b1;
        else begin
          list_remove(0);
          if (cur_valid) begin
            if (cur_idx == 0) cur_valid = 1'b0;
            else cur_idx--;
          end
        end
      end
      cls_pkg::CMD_DEL_BACK: begin
        if (list_len == 0) err = 1'b1;
        else begin
          if (cur_valid && cur_idx == list_len - 1) begin
            cur_valid = 1'b0;
            cur_idx   = 0;
          end
          list_remove(list_len - 1);
        end
      end
      cls_pkg::CMD_DEL_CURSOR: begin
        if (!cur_valid) err = 1'b1;
        else begin
          list_remove(cur_idx);
          cur_valid = 1'b0;
          cur_idx   = 0;
        end
      end
      cls_pkg::CMD_MV_FRONT: begin
        if (list_len > 0) begin
          cur_valid = 1'b1;
          cur_idx   = 0;
        end
      end
      cls_pkg::CMD_MV_BACK: begin
        if (list_len > 0) begin
          cur_valid = 1'b1;
          cur_idx   = list_len - 1;
        end
      end
      cls_pkg::CMD_MV_PREV: begin
        if (cur_valid) begin
          if (cur_idx == 0) cur_valid = 1'b0;
          else cur_idx--;
        end
      end
      cls_pkg::CMD_MV_NEXT: begin
        if (cur_valid) begin
          if (cur_idx + 1 >= list_len) begin
            cur_valid = 1'b0;
            cur_idx   = 0;
          end else begin
            cur_idx++;
          end
        end
      end
      cls_pkg::CMD_SET: begin
        if (!cur_valid) err = 1'b1;
        else list_cells[cur_idx] = v;
      end
      default: begin
      end
    endcase
    if (full && err && c inside {cls_pkg::CMD_PREPEND, cls_pkg::CMD_APPEND,
                                 cls_pkg::CMD_INS_BEFORE, cls_pkg::CMD_INS_AFTER})
      full_refusals++;
    s.count = list_len[COUNT_W-1:0];
    s.pos   = cur_valid ? cur_idx[COUNT_W-1:0] : '1;
    s.ok    = cur_valid;
    s.front = (list_len > 0) ? list_cells[0] : '0;
    s.back  = (list_len > 0) ? list_cells[list_len-1] : '0;
    s.cur   = (cur_valid && cur_idx < list_len) ? list_cells[cur_idx] : '0;
    s.err   = err;
    return s;
  endfunction

  // Present one command beat, hold it until taken, then queue its status
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] v,
                           input bit typed, input list_status_t typed_st);
    list_status_t predicted;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_to_list(c, v);
    pending_status.push_back(typed ? typed_st : predicted);
    cmds_sent++;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] v);
    dir_row_t r;
    r.cmd    = c;
    r.value  = v;
    r.typed  = 1'b0;
    r.status = '0;
    dir_tab.push_back(r);
  endtask

  task automatic add_typed(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] v,
                           input list_status_t s);
    dir_row_t r;
    r.cmd    = c;
    r.value  = v;
    r.typed  = 1'b1;
    r.status = s;
    dir_tab.push_back(r);
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Check each status beat against the oldest expectation
  always @(posedge clk) begin : status_check
    list_status_t exp_st;
    list_status_t got_st;
    if (!rst && out_valid && !out_stall) begin
      got_st = '{count, cursor_pos, cursor_ok, front_value, back_value, cursor_value, error};
      if (pending_status.size() == 0) begin
        note_mismatch($sformatf("unexpected beat %s", status_str(got_st)));
      end else begin
        exp_st = pending_status.pop_front();
        beats_checked++;
        if (got_st.count !== exp_st.count || got_st.pos !== exp_st.pos ||
            got_st.ok !== exp_st.ok || got_st.front !== exp_st.front ||
            got_st.back !== exp_st.back || got_st.cur !== exp_st.cur ||
            got_st.err !== exp_st.err)
          note_mismatch($sformatf("beat %0d\n  exp %s\n  got %s", beats_checked,
                                  status_str(exp_st), status_str(got_st)));
      end
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0]         c;
    logic signed [WORD_W-1:0] v;
    int                       roll;
    bit                       growing;
    list_status_t             empty_ok;
    list_status_t             empty_err;

    empty_ok  = mk_status(0, -1, 1'b0, '0, '0, '0, 1'b0);
    empty_err = mk_status(0, -1, 1'b0, '0, '0, '0, 1'b1);

    // Refusals and no-op moves on the empty list
    add_typed(cls_pkg::CMD_READ,       32'sd0, empty_ok);
    add_typed(cls_pkg::CMD_DEL_FRONT,  32'sd0, empty_err);
    add_typed(cls_pkg::CMD_DEL_BACK,   32'sd0, empty_err);
    add_typed(cls_pkg::CMD_DEL_CURSOR, 32'sd0, empty_err);
    add_typed(cls_pkg::CMD_SET,        32'sd5, empty_err);
    add_typed(cls_pkg::CMD_INS_BEFORE, 32'sd7, empty_err);
    add_typed(cls_pkg::CMD_INS_AFTER,  32'sd7, empty_err);
    add_typed(cls_pkg::CMD_MV_FRONT,   32'sd0, empty_ok);
    add_typed(cls_pkg::CMD_MV_NEXT,    32'sd0, empty_ok);
    // Extreme values at both ends
    add_typed(cls_pkg::CMD_APPEND, MAX_WORD,
              mk_status(1, -1, 1'b0, MAX_WORD, MAX_WORD, '0, 1'b0));
    add_typed(cls_pkg::CMD_PREPEND, MIN_WORD,
              mk_status(2, -1, 1'b0, MIN_WORD, MAX_WORD, '0, 1'b0));
    add_typed(cls_pkg::CMD_MV_BACK, 32'sd0,
              mk_status(2, 1, 1'b1, MIN_WORD, MAX_WORD, MAX_WORD, 1'b0));
    // Inserts around the cursor, prepend under a live cursor
    add_row(cls_pkg::CMD_INS_BEFORE, -32'sd1);
    add_row(cls_pkg::CMD_INS_AFTER,  32'sd0);
    add_row(cls_pkg::CMD_PREPEND,    32'sd1);
    // Step off the back, then off the front
    add_row(cls_pkg::CMD_MV_NEXT,    32'sd0);
    add_row(cls_pkg::CMD_MV_NEXT,    32'sd0);
    add_row(cls_pkg::CMD_MV_FRONT,   32'sd0);
    add_row(cls_pkg::CMD_MV_PREV,    32'sd0);
    // Set, then delete under the cursor at either end
    add_row(cls_pkg::CMD_MV_BACK,    32'sd0);
    add_row(cls_pkg::CMD_SET,        32'sh5A5A_5A5A);
    add_row(cls_pkg::CMD_DEL_BACK,   32'sd0);
    add_row(cls_pkg::CMD_MV_FRONT,   32'sd0);
    add_row(cls_pkg::CMD_DEL_FRONT,  32'sd0);
    add_row(cls_pkg::CMD_MV_BACK,    32'sd0);
    add_row(cls_pkg::CMD_DEL_FRONT,  32'sd0);
    add_row(cls_pkg::CMD_DEL_CURSOR, 32'sd0);
    add_row(CMD_SPARE_A,             32'sd0);
    add_row(CMD_SPARE_B,             32'sd0);
    add_row(cls_pkg::CMD_CLEAR,      32'sd0);

    // Hold reset, then release it before the first command
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 18;
    recv_idle = 65;
    foreach (dir_tab[i]) send_beat(dir_tab[i].cmd, dir_tab[i].value,
                                   dir_tab[i].typed, dir_tab[i].status);

    // Random grow and shrink runs under three idling patterns
    growing = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 18 : (phase == 1) ? 65 : 0;
      recv_idle = (phase == 0) ? 65 : (phase == 1) ? 18 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          c = CMD_W'($urandom_range(0, 15));
        end else if (roll < 60) begin
          c = growing ?
              CMD_W'($urandom_range(cls_pkg::CMD_PREPEND, cls_pkg::CMD_INS_AFTER)) :
              CMD_W'($urandom_range(cls_pkg::CMD_DEL_FRONT, cls_pkg::CMD_DEL_CURSOR));
        end else if (roll < 80) begin
          c = CMD_W'($urandom_range(cls_pkg::CMD_MV_FRONT, cls_pkg::CMD_MV_NEXT));
        end else if (roll < 88) begin
          c = growing ?
              CMD_W'($urandom_range(cls_pkg::CMD_DEL_FRONT, cls_pkg::CMD_DEL_CURSOR)) :
              CMD_W'($urandom_range(cls_pkg::CMD_PREPEND, cls_pkg::CMD_INS_AFTER));
        end else begin
          c = (roll < 95) ? cls_pkg::CMD_SET : cls_pkg::CMD_READ;
        end
        case ($urandom_range(0, 7))
          0:       v = MIN_WORD;
          1:       v = MAX_WORD;
          2:       v = -32'sd1;
          3:       v = 32'sd0;
          default: v = $urandom;
        endcase
        send_beat(c, v, 1'b0, '0);
        // Turn round at the ends: linger while full or empty for a while
        if (growing && list_len == CAPACITY && $urandom_range(0, 3) == 0)
          growing = 1'b0;
        else if (!growing && list_len == 0 && $urandom_range(0, 2) == 0)
          growing = 1'b1;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding status beats
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands, checked %0d status beats, %0d inserts refused on a full store.",
             cmds_sent, beats_checked, full_refusals);
    $display("Mismatches: %0d", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cls_pkg.sv
rtl/cls_cell.sv
rtl/cursor_list_store_core.sv
tb/cursor_list_store_core_tb.sv
